@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the slot allocator RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NFSA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NFSA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/nfsa_pkg.sv @@
// Package for the next-fit slot allocator: sizes, codes and transaction types.
// Used by nfsa_cell and next_fit_slot_allocator; depends on nothing.
package nfsa_pkg;

    localparam int DEFAULT_SLOTS = 128;
    localparam int CELL_SLOTS    = 16;
    localparam int CELL_W        = $clog2(CELL_SLOTS);

    localparam int KIND_W      = 2;
    localparam int INDEX_W     = 7;
    localparam int RANGE_END_W = 8;
    localparam int SLOT_OUT_W  = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC     = 2'd0,
        KIND_COPY      = 2'd1,
        KIND_DEL_ONE   = 2'd2,
        KIND_DEL_RANGE = 2'd3
    } nfsa_kind_t;

    // Operation carried by the token that walks the cell chain.
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_SEARCH = 2'd1,
        OP_CLEAR  = 2'd2
    } nfsa_op_t;

    typedef struct packed {
        logic                   active;
        nfsa_op_t               op;
        logic                   src;
        logic                   found;
    } nfsa_tok_t;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [INDEX_W-1:0]     index;
        logic [RANGE_END_W-1:0] range_end;
    } nfsa_req_t;

    typedef struct packed {
        logic                   ok;
        logic [SLOT_OUT_W-1:0]  slot;
    } nfsa_rsp_t;

endpackage

@@ rtl/core/next_fit_slot_allocator.sv @@
// Next-fit slot allocator, top level. A request transaction allocates, copies or frees
// slots, and every request yields one response transaction with ok and the granted slot.
// Structure: the used bits sit in a chain of ceil(SLOTS/16) cells of 16 slots each, and a
// token walks the chain one cell per cycle; rsp_valid is registered once the token leaves
// the last cell. A new request is taken only once the previous request's response has
// been produced, so requests never overlap in the chain, and every kind of request,
// including deletes and refused allocations, walks the whole chain.
// Allocate searches upward from the cursor, restarting at slot 0 only when the cursor
// stands at SLOTS; free slots below the cursor are not looked at. A failed search sets
// the exhausted flag, and further allocations fail at once until a delete clears it.
// Copy grants a slot the same way, but the new slot inherits the source's used bit.
// Delete-one and delete-range free slots and move the cursor back to the first one.
// A response waiting on a stalled rsp channel does not block the next request: one
// extra response register holds a result that finishes while the output is full.
// Depends on nfsa_pkg, nfsa_cell and assert_macros.svh.
`include "assert_macros.svh"

module next_fit_slot_allocator
    import nfsa_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  nfsa_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output nfsa_rsp_t rsp
);

    localparam int NUM_CELLS = (SLOTS + CELL_SLOTS - 1) / CELL_SLOTS;
    localparam int POS_W     = $clog2(NUM_CELLS * CELL_SLOTS);
    localparam int CUR_W     = $clog2(SLOTS + 1);

    // Token wires between neighboring cells; entry 0 is launched from here.
    nfsa_tok_t        tok_chain [NUM_CELLS+1];
    logic [CUR_W-1:0] lo_chain  [NUM_CELLS+1];
    logic [CUR_W-1:0] hi_chain  [NUM_CELLS+1];
    logic [POS_W-1:0] hit_chain [NUM_CELLS+1];
    logic [NUM_CELLS*CELL_SLOTS-1:0] used_flat;

    logic             busy_reg, busy_next;
    logic [CUR_W-1:0] cursor_reg, cursor_next;
    logic             exhausted_reg, exhausted_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             pend_valid_reg, pend_valid_next;
    nfsa_rsp_t        rsp_reg, rsp_next;
    nfsa_rsp_t        pend_reg, pend_next;

    logic             accept;
    logic             idx_ok;
    logic             end_ok;
    logic             src_bit;
    nfsa_tok_t        tok_exit;
    nfsa_rsp_t        res;

    assign req_ready = !busy_reg && !pend_valid_reg;
    assign accept    = req_valid && req_ready;
    assign idx_ok    = int'(req.index) < SLOTS;
    assign end_ok    = int'(req.range_end) < SLOTS;
    assign src_bit   = idx_ok ? used_flat[POS_W'(req.index)] : 1'b0;

    // Build the token for the accepted request. Deletes become a clear of [lo, hi);
    // a search starts at lo and runs to the top of the slot range.
    always_comb
    begin
        tok_chain[0]        = '0;
        tok_chain[0].active = accept;
        tok_chain[0].op     = OP_NONE;
        lo_chain[0]         = '0;
        hi_chain[0]         = CUR_W'(SLOTS);
        hit_chain[0]        = '0;
        case (nfsa_kind_t'(req.kind))
            KIND_ALLOC, KIND_COPY:
            begin
                tok_chain[0].op  = exhausted_reg ? OP_NONE : OP_SEARCH;
                tok_chain[0].src = (nfsa_kind_t'(req.kind) == KIND_ALLOC) ? 1'b1 : src_bit;
                lo_chain[0]      = (int'(cursor_reg) >= SLOTS) ? '0 : cursor_reg;
            end
            KIND_DEL_ONE:
            begin
                tok_chain[0].op = OP_CLEAR;
                lo_chain[0]     = idx_ok ? CUR_W'(req.index) : CUR_W'(SLOTS);
                hi_chain[0]     = idx_ok ? CUR_W'(req.index) + CUR_W'(1) : CUR_W'(SLOTS);
            end
            KIND_DEL_RANGE:
            begin
                tok_chain[0].op = OP_CLEAR;
                lo_chain[0]     = idx_ok ? CUR_W'(req.index) : CUR_W'(SLOTS);
                hi_chain[0]     = end_ok ? CUR_W'(req.range_end) : CUR_W'(SLOTS);
            end
            default:
            begin
            end
        endcase
    end

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        nfsa_cell #(
            .SLOTS   (SLOTS),
            .CELL_ID (g),
            .CUR_W   (CUR_W),
            .POS_W   (POS_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_chain[g]),
            .lo_in   (lo_chain[g]),
            .hi_in   (hi_chain[g]),
            .hit_in  (hit_chain[g]),
            .tok_out (tok_chain[g+1]),
            .lo_out  (lo_chain[g+1]),
            .hi_out  (hi_chain[g+1]),
            .hit_out (hit_chain[g+1]),
            .used    (used_flat[g*CELL_SLOTS +: CELL_SLOTS])
        );
    end

    assign tok_exit = tok_chain[NUM_CELLS];

    // Result and cursor update once the token leaves the last cell.
    always_comb
    begin
        res            = '0;
        cursor_next    = cursor_reg;
        exhausted_next = exhausted_reg;
        if (tok_exit.active)
        begin
            case (tok_exit.op)
                OP_SEARCH:
                begin
                    if (tok_exit.found)
                    begin
                        res.ok      = 1'b1;
                        res.slot    = SLOT_OUT_W'(hit_chain[NUM_CELLS]);
                        cursor_next = CUR_W'(hit_chain[NUM_CELLS]) + CUR_W'(1);
                    end
                    else
                    begin
                        cursor_next    = CUR_W'(SLOTS);
                        exhausted_next = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    res.ok         = 1'b1;
                    cursor_next    = lo_chain[NUM_CELLS];
                    exhausted_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Response register with one overflow entry.
    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        pend_valid_next = pend_valid_reg;
        rsp_next        = rsp_reg;
        pend_next       = pend_reg;
        busy_next       = busy_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            if (pend_valid_reg)
            begin
                rsp_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
            else
            begin
                rsp_valid_next = 1'b0;
            end
        end
        if (tok_exit.active)
        begin
            busy_next = 1'b0;
            if (!rsp_valid_next)
            begin
                rsp_next       = res;
                rsp_valid_next = 1'b1;
            end
            else
            begin
                pend_next       = res;
                pend_valid_next = 1'b1;
            end
        end
        if (accept)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            cursor_reg     <= '0;
            exhausted_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            cursor_reg     <= cursor_next;
            exhausted_reg  <= exhausted_next;
            rsp_valid_reg  <= rsp_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        pend_reg <= pend_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `NFSA_ASSERT_IMP(a_exit_while_busy, tok_exit.active, busy_reg, "token left chain while idle")
    `NFSA_ASSERT_IMP(a_pend_behind_rsp, pend_valid_reg, rsp_valid_reg, "overflow without response")
    `NFSA_ASSERT_IMP(a_exhausted_cursor, exhausted_reg, cursor_reg == CUR_W'(SLOTS), "exhausted off top")
    `NFSA_ASSERT_NXT(a_accept_busy, accept, busy_reg, "accepted request not in flight")

endmodule

@@ rtl/core/nfsa_cell.sv @@
// One cell of the allocator chain: holds CELL_SLOTS used bits and acts on the token.
// Depends on nfsa_pkg.
module nfsa_cell
    import nfsa_pkg::*;
#(
    parameter int SLOTS   = DEFAULT_SLOTS,
    parameter int CELL_ID = 0,
    parameter int CUR_W   = $clog2(SLOTS + 1),
    parameter int POS_W   = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  nfsa_tok_t             tok_in,
    input  logic [CUR_W-1:0]      lo_in,
    input  logic [CUR_W-1:0]      hi_in,
    input  logic [POS_W-1:0]      hit_in,
    output nfsa_tok_t             tok_out,
    output logic [CUR_W-1:0]      lo_out,
    output logic [CUR_W-1:0]      hi_out,
    output logic [POS_W-1:0]      hit_out,
    output logic [CELL_SLOTS-1:0] used
);

    localparam int BASE = CELL_ID * CELL_SLOTS;

    logic [CELL_SLOTS-1:0] used_reg, used_next;
    nfsa_tok_t             tok_reg, tok_next;
    logic [CUR_W-1:0]      lo_reg, hi_reg;
    logic [POS_W-1:0]      hit_reg, hit_next;
    logic                  hit_here;
    logic [CELL_W-1:0]     hit_j;

    always_comb
    begin
        used_next = used_reg;
        tok_next  = tok_in;
        hit_next  = hit_in;
        hit_here  = 1'b0;
        hit_j     = '0;
        if (tok_in.active)
        begin
            case (tok_in.op)
                OP_CLEAR:
                begin
                    for (int j = 0; j < CELL_SLOTS; j++)
                    begin
                        if ((BASE + j) >= int'(lo_in) && (BASE + j) < int'(hi_in))
                        begin
                            used_next[j] = 1'b0;
                        end
                    end
                end
                OP_SEARCH:
                begin
                    if (!tok_in.found)
                    begin
                        // Lowest free slot in this cell at or above the cursor.
                        for (int j = 0; j < CELL_SLOTS; j++)
                        begin
                            if (!hit_here && (BASE + j) < SLOTS &&
                                (BASE + j) >= int'(lo_in) && !used_reg[j])
                            begin
                                hit_here = 1'b1;
                                hit_j    = CELL_W'(j);
                            end
                        end
                        if (hit_here)
                        begin
                            used_next[hit_j] = tok_in.src;
                            tok_next.found   = 1'b1;
                            hit_next         = POS_W'(BASE) + POS_W'(hit_j);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_in;
        hi_reg  <= hi_in;
        hit_reg <= hit_next;
    end

    assign tok_out = tok_reg;
    assign lo_out  = lo_reg;
    assign hi_out  = hi_reg;
    assign hit_out = hit_reg;
    assign used    = used_reg;

endmodule

@@ test/nfsa_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the next-fit slot allocator: it watches both channels, predicts each grant and compares.
// Depends on nfsa_pkg for the transaction types and the request kinds.
module nfsa_checker
    import nfsa_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_ready,
    input  nfsa_req_t req,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  nfsa_rsp_t rsp,
    output int        mismatches,
    output int        outstanding
);

    logic [SLOTS-1:0] used_map;
    int unsigned      cursor;
    bit               exhausted_flag;
    nfsa_rsp_t        grant_q[$];

    initial mismatches = 0;
    initial outstanding = 0;

    function automatic int unsigned clamp_to_slots(int unsigned v);
        return (v > SLOTS) ? SLOTS : v;
    endfunction

    // Applies one request to the shadow state and returns the grant it should produce.
    task automatic predict_grant(input nfsa_req_t r, output nfsa_rsp_t g);
        int unsigned c;
        int unsigned last;
        logic        src;
        bit          hit;
        g = '0;
        g.ok = 1'b1;
        case (nfsa_kind_t'(r.kind))
            KIND_ALLOC, KIND_COPY:
            begin
                src = 1'b1;
                if (r.kind == KIND_COPY)
                    src = (r.index < SLOTS) ? used_map[r.index] : 1'b0;
                hit = 1'b0;
                if (!exhausted_flag)
                begin
                    c = (cursor >= SLOTS) ? 0 : cursor;
                    while (c < SLOTS && !hit)
                    begin
                        if (!used_map[c])
                            hit = 1'b1;
                        else
                            c++;
                    end
                    if (hit)
                    begin
                        used_map[c] = src;
                        cursor = c + 1;
                        g.slot = c[SLOT_OUT_W-1:0];
                    end
                    else
                    begin
                        cursor = SLOTS;
                        exhausted_flag = 1'b1;
                    end
                end
                if (!hit)
                    g.ok = 1'b0;
            end
            KIND_DEL_ONE:
            begin
                if (r.index < SLOTS)
                    used_map[r.index] = 1'b0;
                cursor = clamp_to_slots(r.index);
                exhausted_flag = 1'b0;
            end
            default:
            begin
                last = clamp_to_slots(r.range_end);
                for (c = r.index; c < last; c++)
                    used_map[c] = 1'b0;
                cursor = clamp_to_slots(r.index);
                exhausted_flag = 1'b0;
            end
        endcase
    endtask

    // Responses are checked before the new request is predicted, since a response
    // seen at an edge always belongs to an older request.
    always @(posedge clk or negedge rst_n)
    begin
        nfsa_rsp_t want;
        nfsa_rsp_t fresh;
        if (!rst_n)
        begin
            used_map = '0;
            cursor = 0;
            exhausted_flag = 1'b0;
            grant_q.delete();
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (grant_q.size() == 0)
                begin
                    $display("%0t: response with nothing expected: ok=%0b slot=%0d",
                             $time, rsp.ok, rsp.slot);
                    mismatches++;
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (rsp.ok !== want.ok)
                    begin
                        $display("%0t: ok mismatch: expected %0b, actual %0b",
                                 $time, want.ok, rsp.ok);
                        mismatches++;
                    end
                    if (rsp.slot !== want.slot)
                    begin
                        $display("%0t: slot mismatch: expected %0d, actual %0d",
                                 $time, want.slot, rsp.slot);
                        mismatches++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                predict_grant(req, fresh);
                grant_q.push_back(fresh);
            end
        end
        outstanding = grant_q.size();
    end

endmodule

@@ test/tb_next_fit_slot_allocator.sv @@
`timescale 1ns / 100ps
// Testbench top for the next-fit slot allocator: clock, reset, request and response traffic, verdict.
// Depends on nfsa_pkg, next_fit_slot_allocator and the nfsa_checker scoreboard.
module tb_next_fit_slot_allocator;
    import nfsa_pkg::*;

    localparam int SLOTS        = DEFAULT_SLOTS;
    localparam int RANDOM_ITEMS = 1600;
    // After this many responses the consumer stops taking them for a long stretch,
    // so the allocator's output buffering fills and it must stall its request side.
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 300;
    // The block raises rsp_valid once a request's token has walked the whole cell chain.
    localparam int DRAIN_CYCLES = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    nfsa_req_t req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    nfsa_rsp_t rsp;

    int mismatches;
    int outstanding;

    // Idle behavior switches between random gaps and back-to-back stretches.
    bit sender_burst = 1'b0;
    bit receiver_burst = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    next_fit_slot_allocator #(.SLOTS(SLOTS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    nfsa_checker #(.SLOTS(SLOTS)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic nfsa_req_t make_request(nfsa_kind_t k, int idx, int last);
        nfsa_req_t r;
        r.kind = k;
        r.index = idx[INDEX_W-1:0];
        r.range_end = last[RANGE_END_W-1:0];
        return r;
    endfunction

    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 7);
    endfunction

    // Random traffic. The share of allocations decides whether the slot map drifts
    // toward full, where exhaustion and refused allocations happen, or toward empty.
    // Deletes pull the cursor back; most ranges are short, a few span the whole map
    // or run past its top. A small share is unconstrained noise.
    function automatic nfsa_req_t random_request(int alloc_share);
        nfsa_req_t r;
        int        pick;
        int        idx;
        pick = $urandom_range(0, 99);
        idx = $urandom_range(0, SLOTS - 1);
        if (pick < 4)
        begin
            r = $bits(nfsa_req_t)'($urandom);
        end
        else if (pick < alloc_share)
        begin
            r = make_request(($urandom_range(0, 2) == 0) ? KIND_COPY : KIND_ALLOC,
                             $urandom_range(0, 127), $urandom_range(0, 255));
        end
        else if (pick < alloc_share + (100 - alloc_share) / 2)
        begin
            r = make_request(KIND_DEL_ONE, idx, $urandom_range(0, 255));
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            r = make_request(KIND_DEL_RANGE, idx, $urandom_range(0, 255));
        end
        else
        begin
            r = make_request(KIND_DEL_RANGE, idx, idx + $urandom_range(0, 12));
        end
        return r;
    endfunction

    // Offers one request transaction and returns at the edge where it is accepted.
    // With a zero gap valid stays high straight into the next transaction.
    task automatic offer(input nfsa_req_t r);
        int gap;
        gap = draw_gap(sender_burst);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Response side: random stalls, back-to-back stretches and one long hold-off.
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        forever
        begin
            if (taken % 50 == 0)
                receiver_burst = ($urandom_range(0, 3) == 0);
            if (taken == HOLD_AFTER)
                stall = HOLD_CYCLES;
            else
                stall = draw_gap(receiver_burst);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            taken++;
        end
    end

    initial
    begin
        int alloc_share;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, walked from reset with the cursor tracked by hand.
        offer(make_request(KIND_ALLOC, 0, 0));          // first grant is slot 0
        offer(make_request(KIND_ALLOC, 127, 255));      // slot 1
        offer(make_request(KIND_COPY, 0, 0));           // used source: slot 2 becomes used
        offer(make_request(KIND_COPY, 127, 0));         // free source: slot 3 granted, stays free
        offer(make_request(KIND_ALLOC, 0, 0));          // free slot 3 lies behind the cursor
        offer(make_request(KIND_DEL_ONE, 1, 0));        // cursor back to 1
        offer(make_request(KIND_ALLOC, 0, 0));          // slot 1 again
        offer(make_request(KIND_DEL_RANGE, 5, 0));      // empty range, only the cursor moves
        offer(make_request(KIND_DEL_RANGE, 0, 255));    // end beyond the top saturates
        offer(make_request(KIND_DEL_ONE, 127, 0));      // cursor to the last slot
        offer(make_request(KIND_ALLOC, 0, 0));          // slot 127, cursor now at the top
        offer(make_request(KIND_ALLOC, 0, 0));          // cursor at the top wraps to slot 0
        offer(make_request(KIND_DEL_RANGE, 127, 127));  // cursor 127, nothing freed
        offer(make_request(KIND_ALLOC, 0, 0));          // nothing free above: exhausted
        offer(make_request(KIND_ALLOC, 0, 0));          // refused at once while exhausted
        offer(make_request(KIND_COPY, 0, 0));           // copy refused while exhausted
        offer(make_request(KIND_DEL_RANGE, 0, 128));    // frees everything, clears the flag
        offer(make_request(KIND_COPY, 127, 128));
        offer(make_request(KIND_DEL_ONE, 0, 255));
        offer(make_request(KIND_DEL_RANGE, 100, 129));
        offer(make_request(KIND_DEL_RANGE, 127, 128));
        offer(make_request(KIND_ALLOC, 85, 170));
        offer(make_request(KIND_COPY, 42, 85));

        // Random part, in phases of changing allocation pressure and idle behavior.
        alloc_share = 75;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: alloc_share = 60;
                    1: alloc_share = 75;
                    default: alloc_share = 92;
                endcase
            end
            if (n % 64 == 0)
                sender_burst = ($urandom_range(0, 3) == 0);
            offer(random_request(alloc_share));
        end
        req_valid <= 1'b0;

        // Wait for the last transaction to reach the scoreboard, then drain.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, including the long hold-off.
    initial
    begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

endmodule
